@@ rtl/core/command_frame_parser_bcd_decode_unit_macros.svh @@
// Assertion macros shared by the frame parser RTL.
// CFP_ASSERT checks on clk_i and is disabled while rst_ni is low.
// CFP_ASSERT_ALWAYS checks on clk_i through reset as well.
`ifndef COMMAND_FRAME_PARSER_BCD_DECODE_UNIT_MACROS_SVH
`define COMMAND_FRAME_PARSER_BCD_DECODE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define CFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CFP_ASSERT(lbl, prop, msg)
`define CFP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/core/cfpbcd_pkg.sv @@
package cfpbcd_pkg;

  localparam int unsigned IvW  = 22;
  localparam int unsigned VlW  = 9;
  localparam int unsigned MagW = 21;

  localparam logic [7:0] HDR0_BYTE  = 8'hEE;
  localparam logic [7:0] HDR1_BYTE  = 8'hAA;
  localparam logic [7:0] TAIL0_BYTE = 8'h00;
  localparam logic [7:0] TAIL1_BYTE = 8'hBB;
  localparam logic [7:0] SIGN_NEG_BYTE = 8'h00;
  localparam logic [7:0] SIGN_POS_BYTE = 8'h01;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_ACCEPT = 2'd1,
    EV_REJECT = 2'd2
  } frame_ev_e;

  typedef enum logic [1:0] {
    SIGN_KEEP = 2'd0,
    SIGN_NEG  = 2'd1,
    SIGN_POS  = 2'd2
  } sign_e;

  // One classified word handed from the parser to the decoder.
  typedef struct packed {
    logic [7:0] echo;
    frame_ev_e  ev;
    logic [7:0] count;
    logic [7:0] cell_step;
    sign_e      iv_sign;
    logic [7:0] iv_hi;
    logic [7:0] iv_mid;
    logic [7:0] iv_lo;
    sign_e      vl_sign;
    logic [7:0] vl_byte;
  } cmd_t;

  function automatic sign_e sign_of(input logic [7:0] b);
    sign_e s;
    if (b == SIGN_NEG_BYTE) begin
      s = SIGN_NEG;
    end else if (b == SIGN_POS_BYTE) begin
      s = SIGN_POS;
    end else begin
      s = SIGN_KEEP;
    end
    return s;
  endfunction

  // Packed BCD pair, nibbles unchecked: 10*high + low, at most 165.
  function automatic logic [7:0] bcd_pair(input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'b0000, b[7:4]};
    lo = {4'b0000, b[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

endpackage

@@ rtl/core/cfpbcd_front.sv @@
`include "command_frame_parser_bcd_decode_unit_macros.svh"

module cfpbcd_front #(
  parameter int unsigned FRAME_LEN = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              q_ready_i,
  output logic              push_o,
  output cfpbcd_pkg::cmd_t  cmd_o
);

  localparam int unsigned PosW = $clog2(FRAME_LEN);
  localparam logic [PosW-1:0] LastPos = PosW'(FRAME_LEN - 1);
  localparam logic [PosW-1:0] TailPos = PosW'(FRAME_LEN - 2);

  cfpbcd_pkg::phase_e phase_q, phase_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [PosW-1:0]    pos_next;
  logic               accept;
  logic               frame_end;
  logic [7:0]         fb_q [2:9];
  logic [7:0]         tail0_q;

  assign accept   = in_valid_i && q_ready_i;
  assign pos_next = pos_q + PosW'(1);

  // Next parse phase and position.
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    frame_end = 1'b0;
    if (accept) begin
      case (phase_q)
        cfpbcd_pkg::PH_IDLE: begin
          pos_d = '0;
          if (rx_byte_i == cfpbcd_pkg::HDR0_BYTE) begin
            phase_d = cfpbcd_pkg::PH_HEADER;
          end
        end
        cfpbcd_pkg::PH_HEADER: begin
          if (rx_byte_i == cfpbcd_pkg::HDR1_BYTE) begin
            phase_d = cfpbcd_pkg::PH_PAYLOAD;
            pos_d   = PosW'(1);
          end else begin
            phase_d = cfpbcd_pkg::PH_IDLE;
            pos_d   = '0;
          end
        end
        cfpbcd_pkg::PH_PAYLOAD: begin
          pos_d = pos_next;
          if (pos_next == LastPos) begin
            frame_end = 1'b1;
            phase_d   = cfpbcd_pkg::PH_IDLE;
            pos_d     = '0;
          end
        end
        default: begin
          phase_d = cfpbcd_pkg::PH_IDLE;
          pos_d   = '0;
        end
      endcase
    end
  end

  // Classified word for the decoder.
  always_comb begin
    cmd_o.echo    = rx_byte_i;
    cmd_o.ev      = cfpbcd_pkg::EV_NONE;
    if (frame_end) begin
      if (tail0_q == cfpbcd_pkg::TAIL0_BYTE && rx_byte_i == cfpbcd_pkg::TAIL1_BYTE) begin
        cmd_o.ev = cfpbcd_pkg::EV_ACCEPT;
      end else begin
        cmd_o.ev = cfpbcd_pkg::EV_REJECT;
      end
    end
    cmd_o.count     = fb_q[2];
    cmd_o.cell_step = fb_q[3];
    cmd_o.iv_sign   = cfpbcd_pkg::sign_of(fb_q[4]);
    cmd_o.iv_hi     = fb_q[5];
    cmd_o.iv_mid    = fb_q[6];
    cmd_o.iv_lo     = fb_q[7];
    cmd_o.vl_sign   = cfpbcd_pkg::sign_of(fb_q[8]);
    cmd_o.vl_byte   = fb_q[9];
    push_o          = accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cfpbcd_pkg::PH_IDLE;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
    end
  end

  // Keep only the payload bytes the decoder and tail check use.
  always_ff @(posedge clk_i) begin
    if (accept && phase_q == cfpbcd_pkg::PH_PAYLOAD) begin
      for (int k = 2; k <= 9; k++) begin
        if (pos_next == PosW'(k)) begin
          fb_q[k] <= rx_byte_i;
        end
      end
      if (pos_next == TailPos) begin
        tail0_q <= rx_byte_i;
      end
    end
  end

  `CFP_ASSERT(a_end_returns_idle,
    (push_o && cmd_o.ev != cfpbcd_pkg::EV_NONE)
      |=> (phase_q == cfpbcd_pkg::PH_IDLE && pos_q == '0),
    "frame end did not return the parser to idle")

endmodule

@@ rtl/core/cfpbcd_fifo.sv @@
module cfpbcd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cfpbcd_pkg::cmd_t  wdata_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_i,
  output cfpbcd_pkg::cmd_t  rdata_o
);

  cfpbcd_pkg::cmd_t ent_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign rdata_o = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ rtl/core/cfpbcd_back.sv @@
`include "command_frame_parser_bcd_decode_unit_macros.svh"

module cfpbcd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  cfpbcd_pkg::cmd_t              cmd_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    echo_byte_o,
  output logic [1:0]                    frame_event_o,
  output logic [7:0]                    item_count_setting_o,
  output logic [7:0]                    cell_step_setting_o,
  output logic [1:0]                    gain_class_o,
  output logic signed [cfpbcd_pkg::IvW-1:0] interval_value_o,
  output logic signed [cfpbcd_pkg::VlW-1:0] velocity_value_o
);

  logic                              out_valid_q;
  logic [7:0]                        echo_q;
  cfpbcd_pkg::frame_ev_e             ev_q;
  logic [7:0]                        count_q, count_d;
  logic [7:0]                        cell_q, cell_d;
  logic [1:0]                        class_q, class_d;
  logic signed [cfpbcd_pkg::IvW-1:0] iv_q, iv_d;
  logic signed [cfpbcd_pkg::VlW-1:0] vl_q, vl_d;
  logic [cfpbcd_pkg::MagW-1:0]       iv_mag;
  logic signed [cfpbcd_pkg::IvW-1:0] iv_mag_s;
  logic signed [cfpbcd_pkg::VlW-1:0] vl_mag_s;
  logic [1:0]                        new_class;

  // Take a word only when the result slot is free or being emptied.
  assign pop_o = valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    iv_mag = cfpbcd_pkg::MagW'(cfpbcd_pkg::bcd_pair(cmd_i.iv_hi)) * cfpbcd_pkg::MagW'(10000)
           + cfpbcd_pkg::MagW'(cfpbcd_pkg::bcd_pair(cmd_i.iv_mid)) * cfpbcd_pkg::MagW'(100)
           + cfpbcd_pkg::MagW'(cfpbcd_pkg::bcd_pair(cmd_i.iv_lo));
    iv_mag_s = $signed({1'b0, iv_mag});
    vl_mag_s = $signed({1'b0, cfpbcd_pkg::bcd_pair(cmd_i.vl_byte)});

    if (cmd_i.cell_step inside {[8'd0:8'd2]}) begin
      new_class = 2'd0;
    end else if (cmd_i.cell_step == 8'd3) begin
      new_class = 2'd1;
    end else if (cmd_i.cell_step == 8'd4) begin
      new_class = 2'd2;
    end else begin
      new_class = 2'd3;
    end
  end

  always_comb begin
    count_d = count_q;
    cell_d  = cell_q;
    class_d = class_q;
    iv_d    = iv_q;
    vl_d    = vl_q;
    case (cmd_i.ev)
      cfpbcd_pkg::EV_ACCEPT: begin
        count_d = cmd_i.count;
        cell_d  = cmd_i.cell_step;
        class_d = new_class;
        case (cmd_i.iv_sign)
          cfpbcd_pkg::SIGN_NEG: iv_d = -iv_mag_s;
          cfpbcd_pkg::SIGN_POS: iv_d = iv_mag_s;
          default:              iv_d = iv_q;
        endcase
        case (cmd_i.vl_sign)
          cfpbcd_pkg::SIGN_NEG: vl_d = -vl_mag_s;
          cfpbcd_pkg::SIGN_POS: vl_d = vl_mag_s;
          default:              vl_d = vl_q;
        endcase
      end
      cfpbcd_pkg::EV_REJECT: begin
        iv_d = '0;
        vl_d = '0;
      end
      default: begin
        iv_d = iv_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
      cell_q      <= '0;
      class_q     <= '0;
      iv_q        <= '0;
      vl_q        <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
        cell_q      <= cell_d;
        class_q     <= class_d;
        iv_q        <= iv_d;
        vl_q        <= vl_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      echo_q <= cmd_i.echo;
      ev_q   <= cmd_i.ev;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign echo_byte_o          = echo_q;
  assign frame_event_o        = ev_q;
  assign item_count_setting_o = count_q;
  assign cell_step_setting_o  = cell_q;
  assign gain_class_o         = class_q;
  assign interval_value_o     = iv_q;
  assign velocity_value_o     = vl_q;

  `CFP_ASSERT(a_reject_clears,
    (pop_o && cmd_i.ev == cfpbcd_pkg::EV_REJECT) |=> (iv_q == '0 && vl_q == '0),
    "rejected frame did not clear interval and velocity")
  `CFP_ASSERT(a_accept_latches_cell,
    (pop_o && cmd_i.ev == cfpbcd_pkg::EV_ACCEPT) |=> (cell_q == $past(cmd_i.cell_step)),
    "accepted frame did not latch the cell value")
  `CFP_ASSERT_ALWAYS(a_settings_hold_while_waiting,
    (rst_ni && $past(rst_ni) && $past(out_valid_q && !out_ready_i)) |-> $stable(iv_q),
    "interval changed while a result was waiting")

endmodule

@@ rtl/core/command_frame_parser_bcd_decode_unit.sv @@
// Channel   Handshake                  Payload
// --------  -------------------------  -------------------------------------------
// in        in_valid_i / in_ready_o    rx_byte_i
// out       out_valid_o / out_ready_i  echo_byte_o, frame_event_o,
//                                      item_count_setting_o, cell_step_setting_o,
//                                      gain_class_o, interval_value_o, velocity_value_o
//
// Sustains one word per cycle in and out; each input word yields exactly one result.
// From input accept to out_valid_o a word passes through the two-entry queue
// between parser and decoder, then through the decoder's result register.
// rst_ni (async, active low) returns the parser to idle and clears all latched settings.
// Either side may stall on its own: in_ready_o drops only when the queue is full.
module command_frame_parser_bcd_decode_unit #(
  parameter int unsigned FRAME_LEN = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [7:0]                        echo_byte_o,
  output logic [1:0]                        frame_event_o,
  output logic [7:0]                        item_count_setting_o,
  output logic [7:0]                        cell_step_setting_o,
  output logic [1:0]                        gain_class_o,
  output logic signed [cfpbcd_pkg::IvW-1:0] interval_value_o,
  output logic signed [cfpbcd_pkg::VlW-1:0] velocity_value_o
);

  // Parser to queue.
  logic             push;
  cfpbcd_pkg::cmd_t push_cmd;
  // Queue to decoder.
  logic             q_valid;
  logic             pop;
  cfpbcd_pkg::cmd_t pop_cmd;

  // Front: track header, position and tail; snapshot the payload bytes.
  cfpbcd_front #(
    .FRAME_LEN (FRAME_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .q_ready_i  (in_ready_o),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Two entries decouple the parser from a stalled output.
  cfpbcd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .ready_o (in_ready_o),
    .valid_o (q_valid),
    .pop_i   (pop),
    .rdata_o (pop_cmd)
  );

  // Back: decode BCD, apply signs, update settings, hold the result.
  cfpbcd_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .valid_i              (q_valid),
    .cmd_i                (pop_cmd),
    .pop_o                (pop),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .echo_byte_o          (echo_byte_o),
    .frame_event_o        (frame_event_o),
    .item_count_setting_o (item_count_setting_o),
    .cell_step_setting_o  (cell_step_setting_o),
    .gain_class_o         (gain_class_o),
    .interval_value_o     (interval_value_o),
    .velocity_value_o     (velocity_value_o)
  );

endmodule

@@ dv/bcd_frame_checker.sv @@
`timescale 1ns / 100ps

module bcd_frame_checker #(
  parameter int unsigned FRAME_LEN = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [7:0]                       rx_byte_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [7:0]                       echo_byte_i,
  input  logic [1:0]                       frame_event_i,
  input  logic [7:0]                       item_count_setting_i,
  input  logic [7:0]                       cell_step_setting_i,
  input  logic [1:0]                       gain_class_i,
  input  logic signed [cfpbcd_pkg::IvW-1:0] interval_value_i,
  input  logic signed [cfpbcd_pkg::VlW-1:0] velocity_value_i,
  output int                               pending_o,
  output int                               mismatches_o
);

  typedef enum logic [1:0] {
    GAIN_UP_TO_TWO  = 2'd0,
    GAIN_THREE      = 2'd1,
    GAIN_FOUR       = 2'd2,
    GAIN_ABOVE_FOUR = 2'd3
  } gain_e;

  typedef struct {
    logic [7:0]                        echo;
    cfpbcd_pkg::frame_ev_e             ev;
    logic [7:0]                        count;
    logic [7:0]                        cell_step;
    gain_e                             gain;
    logic signed [cfpbcd_pkg::IvW-1:0] interval;
    logic signed [cfpbcd_pkg::VlW-1:0] velocity;
  } reply_t;

  // Shadow of the parser and of the latched settings.
  cfpbcd_pkg::phase_e                parse_phase;
  logic [5:0]                        byte_pos;
  logic [7:0]                        frame_mem [FRAME_LEN];
  logic [7:0]                        count_q;
  logic [7:0]                        cell_q;
  gain_e                             gain_q;
  logic signed [cfpbcd_pkg::IvW-1:0] interval_q;
  logic signed [cfpbcd_pkg::VlW-1:0] velocity_q;

  reply_t expected_replies [$];
  reply_t want;
  int     reply_idx;

  function automatic int digit_pair(input logic [7:0] b);
    return int'(b[7:4]) * 10 + int'(b[3:0]);
  endfunction

  // Advance the parser by one word and return the reply it produces.
  function automatic reply_t parse_and_decode(input logic [7:0] rx);
    reply_t r;
    logic   keep;
    int     mag;
    keep = 1'b1;
    r.ev = cfpbcd_pkg::EV_NONE;
    case (parse_phase)
      cfpbcd_pkg::PH_IDLE: begin
        byte_pos = '0;
        if (rx == cfpbcd_pkg::HDR0_BYTE) begin
          parse_phase = cfpbcd_pkg::PH_HEADER;
        end else begin
          keep = 1'b0;
        end
      end
      cfpbcd_pkg::PH_HEADER: begin
        if (rx == cfpbcd_pkg::HDR1_BYTE) begin
          parse_phase = cfpbcd_pkg::PH_PAYLOAD;
          byte_pos = 6'd1;
        end else begin
          parse_phase = cfpbcd_pkg::PH_IDLE;
          byte_pos = '0;
          keep = 1'b0;
        end
      end
      cfpbcd_pkg::PH_PAYLOAD: begin
        byte_pos = byte_pos + 6'd1;
      end
      default: begin
        parse_phase = cfpbcd_pkg::PH_IDLE;
        byte_pos = '0;
        keep = 1'b0;
      end
    endcase

    if (keep) begin
      if (byte_pos < FRAME_LEN) frame_mem[byte_pos] = rx;
      if (byte_pos >= FRAME_LEN - 1) begin
        parse_phase = cfpbcd_pkg::PH_IDLE;
        byte_pos = '0;
        if (frame_mem[FRAME_LEN-2] == cfpbcd_pkg::TAIL0_BYTE
            && frame_mem[FRAME_LEN-1] == cfpbcd_pkg::TAIL1_BYTE) begin
          r.ev = cfpbcd_pkg::EV_ACCEPT;
          count_q = frame_mem[2];
          cell_q = frame_mem[3];
          if (cell_q <= 8'd2) begin
            gain_q = GAIN_UP_TO_TWO;
          end else if (cell_q == 8'd3) begin
            gain_q = GAIN_THREE;
          end else if (cell_q == 8'd4) begin
            gain_q = GAIN_FOUR;
          end else begin
            gain_q = GAIN_ABOVE_FOUR;
          end
          mag = digit_pair(frame_mem[5]) * 10000 + digit_pair(frame_mem[6]) * 100
              + digit_pair(frame_mem[7]);
          if (frame_mem[4] == cfpbcd_pkg::SIGN_NEG_BYTE) begin
            interval_q = cfpbcd_pkg::IvW'(-mag);
          end else if (frame_mem[4] == cfpbcd_pkg::SIGN_POS_BYTE) begin
            interval_q = cfpbcd_pkg::IvW'(mag);
          end
          mag = digit_pair(frame_mem[9]);
          if (frame_mem[8] == cfpbcd_pkg::SIGN_NEG_BYTE) begin
            velocity_q = cfpbcd_pkg::VlW'(-mag);
          end else if (frame_mem[8] == cfpbcd_pkg::SIGN_POS_BYTE) begin
            velocity_q = cfpbcd_pkg::VlW'(mag);
          end
        end else begin
          r.ev = cfpbcd_pkg::EV_REJECT;
          interval_q = '0;
          velocity_q = '0;
        end
      end
    end

    r.echo = rx;
    r.count = count_q;
    r.cell_step = cell_q;
    r.gain = gain_q;
    r.interval = interval_q;
    r.velocity = velocity_q;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int exp_val);
    $display("%0t ns reply %0d: %s is %0d, want %0d", $time, reply_idx, what, got, exp_val);
    mismatches_o = mismatches_o + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_phase = cfpbcd_pkg::PH_IDLE;
      byte_pos = '0;
      count_q = '0;
      cell_q = '0;
      gain_q = GAIN_UP_TO_TWO;
      interval_q = '0;
      velocity_q = '0;
      expected_replies.delete();
      reply_idx = 0;
      pending_o = 0;
      mismatches_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_replies.push_back(parse_and_decode(rx_byte_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_replies.size() == 0) begin
          flag_mismatch("reply with nothing pending, echo", echo_byte_i, -1);
        end else begin
          want = expected_replies.pop_front();
          if (echo_byte_i != want.echo) flag_mismatch("echo", echo_byte_i, want.echo);
          if (frame_event_i != want.ev) flag_mismatch("event", frame_event_i, want.ev);
          if (item_count_setting_i != want.count) begin
            flag_mismatch("count", item_count_setting_i, want.count);
          end
          if (cell_step_setting_i != want.cell_step) begin
            flag_mismatch("cell step", cell_step_setting_i, want.cell_step);
          end
          if (gain_class_i != want.gain) flag_mismatch("gain class", gain_class_i, want.gain);
          if (interval_value_i != want.interval) begin
            flag_mismatch("interval", int'(interval_value_i), int'(want.interval));
          end
          if (velocity_value_i != want.velocity) begin
            flag_mismatch("velocity", int'(velocity_value_i), int'(want.velocity));
          end
        end
        reply_idx = reply_idx + 1;
      end
      pending_o = expected_replies.size();
    end
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned FRAME_LEN   = 12;
  localparam int          RANDOM_WORDS = 1000;
  localparam int          HOLD_CYCLES = 80;
  localparam int          MAX_GAP     = 18;
  localparam int          CYCLE_LIMIT = 400000;

  logic                              clk;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [7:0]                        rx_byte = 8'h00;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [7:0]                        echo_byte;
  logic [1:0]                        frame_event;
  logic [7:0]                        item_count;
  logic [7:0]                        cell_step;
  logic [1:0]                        gain_class;
  logic signed [cfpbcd_pkg::IvW-1:0] interval_value;
  logic signed [cfpbcd_pkg::VlW-1:0] velocity_value;

  int pending;
  int mismatches;
  int cycle_count = 0;

  // Shared between the stimulus and the drain process.
  bit calm = 1'b0;          // no idling on either side while set
  bit hold_request = 1'b0;  // ask the drain side for one long hold-off

  logic [7:0] frame_buf [FRAME_LEN];

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  command_frame_parser_bcd_decode_unit #(
    .FRAME_LEN(FRAME_LEN)
  ) u_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .rx_byte_i           (rx_byte),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .echo_byte_o         (echo_byte),
    .frame_event_o       (frame_event),
    .item_count_setting_o(item_count),
    .cell_step_setting_o (cell_step),
    .gain_class_o        (gain_class),
    .interval_value_o    (interval_value),
    .velocity_value_o    (velocity_value)
  );

  bcd_frame_checker #(
    .FRAME_LEN(FRAME_LEN)
  ) u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .rx_byte_i           (rx_byte),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .echo_byte_i         (echo_byte),
    .frame_event_i       (frame_event),
    .item_count_setting_i(item_count),
    .cell_step_setting_i (cell_step),
    .gain_class_i        (gain_class),
    .interval_value_i    (interval_value),
    .velocity_value_i    (velocity_value),
    .pending_o           (pending),
    .mismatches_o        (mismatches)
  );

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one word. Idle for a random gap first, then hold valid and the byte
  // until the block takes it. Return on the falling edge after the accept with
  // valid still high, so a back-to-back word needs no second assignment.
  task automatic send_word(input logic [7:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_frame();
    for (int i = 0; i < FRAME_LEN; i++) send_word(frame_buf[i]);
  endtask

  // Drop valid and hold off until every reply is back.
  task automatic drain_all();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Mostly 0 or 1; now and then an odd byte so the old value is kept.
  function automatic logic [7:0] pick_sign();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return cfpbcd_pkg::SIGN_NEG_BYTE;
    if (r < 8) return cfpbcd_pkg::SIGN_POS_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly decimal digit pairs; one in four is any byte, nibbles above 9 included.
  function automatic logic [7:0] pick_bcd();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  // Build a frame with random content; corrupt the tail when asked.
  function automatic void fill_random_frame(input bit bad_tail);
    frame_buf[0] = cfpbcd_pkg::HDR0_BYTE;
    frame_buf[1] = cfpbcd_pkg::HDR1_BYTE;
    frame_buf[2] = 8'($urandom_range(0, 255));
    // Keep the cell step near the class boundaries most of the time.
    frame_buf[3] = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 6))
                                               : 8'($urandom_range(0, 255));
    frame_buf[4] = pick_sign();
    frame_buf[5] = pick_bcd();
    frame_buf[6] = pick_bcd();
    frame_buf[7] = pick_bcd();
    frame_buf[8] = pick_sign();
    frame_buf[9] = pick_bcd();
    frame_buf[FRAME_LEN-2] = cfpbcd_pkg::TAIL0_BYTE;
    frame_buf[FRAME_LEN-1] = cfpbcd_pkg::TAIL1_BYTE;
    if (bad_tail) begin
      case ($urandom_range(0, 2))
        0: frame_buf[FRAME_LEN-2] = 8'($urandom_range(1, 255));
        1: frame_buf[FRAME_LEN-1] = 8'($urandom_range(0, 255)) ^ cfpbcd_pkg::TAIL1_BYTE
                                    | 8'h01;
        default: begin
          frame_buf[FRAME_LEN-2] = 8'($urandom_range(0, 255));
          frame_buf[FRAME_LEN-1] = 8'($urandom_range(0, 255));
        end
      endcase
    end
  endfunction

  // Line noise between frames. A stray header byte is followed by something
  // other than the second header byte, so the parser drops back to idle.
  task automatic send_noise();
    int         n;
    logic [7:0] b;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      send_word(b);
      if (b == cfpbcd_pkg::HDR0_BYTE) begin
        do b = 8'($urandom_range(0, 255)); while (b == cfpbcd_pkg::HDR1_BYTE);
        send_word(b);
      end
    end
  endtask

  // Header plus a few random payload words, cut short.
  task automatic n_trunc_frame(inout int words);
    int n;
    n = $urandom_range(0, FRAME_LEN - 4);
    send_word(cfpbcd_pkg::HDR0_BYTE);
    send_word(cfpbcd_pkg::HDR1_BYTE);
    for (int i = 0; i < n; i++) send_word(8'($urandom_range(0, 255)));
    words += n + 2;
  endtask

  // Drain side: draw a stall per reply, and serve one long hold-off on request
  // so the internal queue fills and in_ready drops.
  initial begin : drain_side
    int stall;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) @(negedge clk);
        hold_request = 1'b0;
      end
      stall = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int  frame_words;
    int  pick;
    bit  held;
    bit  drained;

    frame_words = 0;
    held = 1'b0;
    drained = 1'b0;

    // Hold reset, then release it on a falling edge.
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Stray byte while idle, then a header start followed by a second 0xEE:
    // the second one must not restart the header.
    send_word(8'h00);
    send_word(cfpbcd_pkg::HDR0_BYTE);
    send_word(cfpbcd_pkg::HDR0_BYTE);

    // Good frame at the negative extremes: full count, cell step of four,
    // all-ones nibbles in every BCD byte.
    frame_buf = '{cfpbcd_pkg::HDR0_BYTE, cfpbcd_pkg::HDR1_BYTE, 8'hFF, 8'h04,
                  cfpbcd_pkg::SIGN_NEG_BYTE, 8'hFF, 8'hFF, 8'hFF,
                  cfpbcd_pkg::SIGN_NEG_BYTE, 8'hFF,
                  cfpbcd_pkg::TAIL0_BYTE, cfpbcd_pkg::TAIL1_BYTE};
    send_frame();

    // Same layout with the tail bytes swapped: reject and clear.
    frame_buf = '{cfpbcd_pkg::HDR0_BYTE, cfpbcd_pkg::HDR1_BYTE, 8'h00, 8'h00,
                  cfpbcd_pkg::SIGN_POS_BYTE, 8'h99, 8'h99, 8'h99,
                  cfpbcd_pkg::SIGN_POS_BYTE, 8'h99,
                  cfpbcd_pkg::TAIL1_BYTE, cfpbcd_pkg::TAIL0_BYTE};
    send_frame();

    while (frame_words < RANDOM_WORDS) begin
      // Alternate busy stretches with stretches of back-to-back traffic.
      calm = ((frame_words / 128) % 3) == 1;

      if (!held && frame_words >= 300) begin
        hold_request = 1'b1;
        held = 1'b1;
      end
      if (!drained && frame_words >= 600) begin
        drain_all();
        drained = 1'b1;
      end

      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        fill_random_frame(1'b0);
        send_frame();
        frame_words += FRAME_LEN;
      end else if (pick < 84) begin
        fill_random_frame(1'b1);
        send_frame();
        frame_words += FRAME_LEN;
      end else if (pick < 90) begin
        // Truncated frame: the next words get swallowed as payload.
        n_trunc_frame(frame_words);
      end else begin
        send_noise();
      end
    end

    drain_all();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/cfpbcd_pkg.sv
rtl/core/cfpbcd_front.sv
rtl/core/cfpbcd_fifo.sv
rtl/core/cfpbcd_back.sv
rtl/core/command_frame_parser_bcd_decode_unit.sv
dv/bcd_frame_checker.sv
dv/testbench.sv
